### rtl/xsr_pkg.sv
// Shared types and constants for the xorshift1024* generator.
`timescale 1ns / 1ps
package xsr_pkg;

	localparam int unsigned WORD_COUNT = 16;
	localparam int unsigned IDX_W      = $clog2(WORD_COUNT);
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned HALF_W     = WORD_W / 2;

	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D049BB133111EB;
	localparam logic [WORD_W-1:0] OUT_MUL     = 64'h9E3779B97F4A7C13;

	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_NEXT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_NEXT_WAIT,
		ST_SEED_A,
		ST_SEED_WAIT_A,
		ST_SEED_WAIT_B
	} state_t;

	typedef enum logic [1:0] {
		MSTEP_LL,
		MSTEP_LH,
		MSTEP_HL
	} mstep_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] c;
	} mul_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] p;
	} mul_rsp_t;

endpackage

### rtl/xsr_mem.sv
// Sixteen-word state store with per-word valid bits and registered dual read.
`timescale 1ns / 1ps
module xsr_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  xsr_pkg::mem_wr_t              wr,
	input  logic [xsr_pkg::IDX_W-1:0]     raddr_a,
	input  logic [xsr_pkg::IDX_W-1:0]     raddr_b,
	output logic [xsr_pkg::WORD_W-1:0]    rdata_a,
	output logic [xsr_pkg::WORD_W-1:0]    rdata_b
);
	import xsr_pkg::*;

	logic [WORD_W-1:0]     mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] valid_q;
	logic [WORD_W-1:0]     rdata_a_q;
	logic [WORD_W-1:0]     rdata_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_a_q <= valid_q[raddr_a] ? mem[raddr_a] : '0;
		rdata_b_q <= valid_q[raddr_b] ? mem[raddr_b] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

### rtl/xsr_mul.sv
// Iterative 64x64 low-half multiplier built on one shared 32x32 multiplier.
`timescale 1ns / 1ps
module xsr_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  xsr_pkg::mul_req_t req,
	output xsr_pkg::mul_rsp_t rsp
);
	import xsr_pkg::*;

	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] c_q;
	logic [WORD_W-1:0] acc_q;
	mstep_t            step_q;
	logic              busy_q;
	logic              done_q;
	logic [HALF_W-1:0] x;
	logic [HALF_W-1:0] y;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] acc_d;

	always_comb begin
		case (step_q)
			MSTEP_LL: begin
				x = a_q[HALF_W-1:0];
				y = c_q[HALF_W-1:0];
			end
			MSTEP_LH: begin
				x = a_q[HALF_W-1:0];
				y = c_q[WORD_W-1:HALF_W];
			end
			MSTEP_HL: begin
				x = a_q[WORD_W-1:HALF_W];
				y = c_q[HALF_W-1:0];
			end
			default: begin
				x = '0;
				y = '0;
			end
		endcase
		prod = WORD_W'(x) * WORD_W'(y);
		if (step_q == MSTEP_LL) begin
			acc_d = prod;
		end else begin
			acc_d = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			c_q <= req.c;
		end
		if (busy_q) begin
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= MSTEP_LL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= MSTEP_LL;
			end else if (busy_q) begin
				case (step_q)
					MSTEP_LL: step_q <= MSTEP_LH;
					MSTEP_LH: step_q <= MSTEP_HL;
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						step_q <= MSTEP_LL;
					end
				endcase
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiply started while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q && step_q == MSTEP_HL))
		else $error("multiply done without final step");

endmodule

### rtl/xsr_mem_dummy_never.sv
// Sequencer for the xorshift1024* generator: seeding walk and next-word update.
`timescale 1ns / 1ps
module xsr_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       command,
	input  logic [xsr_pkg::WORD_W-1:0] seed_value,
	input  logic [xsr_pkg::WORD_W-1:0] rdata_a,
	input  logic [xsr_pkg::WORD_W-1:0] rdata_b,
	input  xsr_pkg::mul_rsp_t          mul_rsp,
	output logic                       busy,
	output logic [xsr_pkg::IDX_W-1:0]  raddr_a,
	output logic [xsr_pkg::IDX_W-1:0]  raddr_b,
	output xsr_pkg::mem_wr_t           wr,
	output xsr_pkg::mul_req_t          mul_req,
	output logic                       done,
	output logic [xsr_pkg::WORD_W-1:0] random_value
);
	import xsr_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] run_q;
	logic              done_q;
	logic [WORD_W-1:0] random_value_q;
	logic              accept;
	logic              seed_go;
	logic              pos_inc;
	logic              word_done;
	logic              out_load;
	logic [WORD_W-1:0] b;
	logic [WORD_W-1:0] mixed;
	logic [WORD_W-1:0] p;

	assign accept  = start && (state_q == ST_IDLE);
	assign raddr_a = pos_q;
	assign raddr_b = pos_q + IDX_W'(1);
	assign p       = mul_rsp.p;
	assign b       = rdata_b ^ (rdata_b << 31);
	assign mixed   = b ^ rdata_a ^ (b >> 11) ^ (rdata_a >> 30);

	always_comb begin
		state_d       = state_q;
		wr            = '0;
		mul_req       = '0;
		seed_go       = 1'b0;
		pos_inc       = 1'b0;
		word_done     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_NEXT) begin
						state_d = ST_MIX;
					end else begin
						seed_go = 1'b1;
						state_d = ST_SEED_A;
					end
				end
			end
			ST_MIX: begin
				wr.en         = 1'b1;
				wr.addr       = raddr_b;
				wr.data       = mixed;
				mul_req.start = 1'b1;
				mul_req.a     = mixed;
				mul_req.c     = OUT_MUL;
				pos_inc       = 1'b1;
				state_d       = ST_NEXT_WAIT;
			end
			ST_NEXT_WAIT: begin
				if (mul_rsp.done) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SEED_A: begin
				mul_req.start = 1'b1;
				mul_req.a     = run_q ^ (run_q >> 30);
				mul_req.c     = MIX_MUL_A;
				state_d       = ST_SEED_WAIT_A;
			end
			ST_SEED_WAIT_A: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = p ^ (p >> 27);
					mul_req.c     = MIX_MUL_B;
					state_d       = ST_SEED_WAIT_B;
				end
			end
			ST_SEED_WAIT_B: begin
				if (mul_rsp.done) begin
					wr.en     = 1'b1;
					wr.addr   = idx_q;
					wr.data   = p ^ (p >> 31);
					word_done = 1'b1;
					state_d   = (idx_q == IDX_W'(WORD_COUNT - 1)) ? ST_IDLE : ST_SEED_A;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_load;
			if (seed_go) begin
				pos_q <= '0;
				idx_q <= '0;
			end else begin
				if (pos_inc) begin
					pos_q <= pos_q + IDX_W'(1);
				end
				if (word_done) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seed_go) begin
			run_q <= seed_value + GOLDEN_STEP;
		end else if (word_done) begin
			run_q <= run_q + GOLDEN_STEP;
		end
		if (out_load) begin
			random_value_q <= p;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign random_value = random_value_q;

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("back-to-back result words");

	a_seed_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED_A) |-> (pos_q == '0))
		else $error("position not cleared during seeding");

	a_mul_idle_on_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX || state_q == ST_SEED_A) |-> !mul_rsp.busy)
		else $error("multiplier busy when a new product is issued");

endmodule

### rtl/xorshift1024_star_rng.sv
// Next: ST_MIX issues the product, ST_NEXT_WAIT loads it, then done rises; no new command until idle.
// Seed: busy through ST_SEED_A and two 3-step multiplies for each of the 16 state words.
// The shared 32x32 multiplier takes three steps per 64-bit product.
// Reset (arst_n low) clears position and the valid bits, so all state words read as zero; no clearing pass.
// Each result word shows for one cycle on done; the receiver cannot stall it.
`timescale 1ns / 1ps
module xorshift1024_star_rng (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [xsr_pkg::WORD_W-1:0] seed_value,
	output logic                       done,
	output logic [xsr_pkg::WORD_W-1:0] random_value
);
	import xsr_pkg::*;

	mem_wr_t           wr;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	logic [IDX_W-1:0]  raddr_a;
	logic [IDX_W-1:0]  raddr_b;
	logic [WORD_W-1:0] rdata_a;
	logic [WORD_W-1:0] rdata_b;

	xsr_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	xsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	xsr_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.seed_value   (seed_value),
		.rdata_a      (rdata_a),
		.rdata_b      (rdata_b),
		.mul_rsp      (mul_rsp),
		.busy         (busy),
		.raddr_a      (raddr_a),
		.raddr_b      (raddr_b),
		.wr           (wr),
		.mul_req      (mul_req),
		.done         (done),
		.random_value (random_value)
	);

endmodule
